[src/gaussian_blur_5x5_rgb_top_defines.svh]
// ----------------------------------------------------------------------------
// gaussian blur 5x5 rgb - assertion macros
// shared assertion helpers for the blur block, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5X5_RGB_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RGB_TOP_DEFINES_SVH

// antecedent holds, consequent must hold in the next cycle
`define GB5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define GB5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/gb5_pkg.sv]
// ----------------------------------------------------------------------------
// gb5_pkg - shared types and constants
// sizes, register indexes, kernel classes and the structs passed between
// the blur submodules
// ----------------------------------------------------------------------------
package gb5_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COEF_FRAC  = 16;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int PAIR_W     = CH_W + 1;
    localparam int WIN_N      = 5;
    localparam int NUM_BANKS  = 4;
    localparam int BANK_W     = $clog2(NUM_BANKS);

    localparam int DIM_W      = 12;
    localparam int MAX_DIM    = 2048;
    localparam int WIDTH_CAP  = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;
    localparam int COL_W      = $clog2(WIDTH_CAP);
    localparam int OROW_W     = $clog2(MAX_DIM);
    localparam int LB_ADDR_W  = $clog2(MAX_WIDTH);

    localparam int COEF_W     = 16;
    localparam int NUM_CLS    = 6;
    localparam int CSUM_W     = CH_W + 3;
    localparam int PROD_W     = CSUM_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;

    localparam logic [DIM_W-1:0] MIN_DIM_V   = DIM_W'(5);
    localparam logic [DIM_W-1:0] WIDTH_CAP_V = DIM_W'(WIDTH_CAP);
    localparam logic [DIM_W-1:0] HEIGHT_CAP_V = DIM_W'(MAX_DIM);

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_D0      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_D1      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_D2      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_D4      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_D5      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_D8      = 3'd7;

    // kernel distance classes
    localparam int CLS_D0 = 0;
    localparam int CLS_D1 = 1;
    localparam int CLS_D2 = 2;
    localparam int CLS_D4 = 3;
    localparam int CLS_D5 = 4;
    localparam int CLS_D8 = 5;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [COEF_W-1:0] RST_COEF [NUM_CLS] = '{
        16'd5591, 16'd4477, 16'd3585, 16'd2298, 16'd1840, 16'd945
    };

    typedef logic [PIX_W-1:0]                    t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0]         t_wcol;
    typedef logic [NUM_BANKS-1:0][PIX_W-1:0]     t_lcol;
    typedef logic [NUM_CLS-1:0][CSUM_W-1:0]      t_csum;
    typedef logic [NUM_CLS-1:0][PROD_W-1:0]      t_prod;

    // per-column partial sums: outer rows, middle rows, center row
    typedef struct packed {
        logic [NUM_CH-1:0][PAIR_W-1:0] outer;
        logic [NUM_CH-1:0][PAIR_W-1:0] mid;
        logic [NUM_CH-1:0][CH_W-1:0]   ctr;
    } t_psum;

    // per-beat control from the position counters
    typedef struct packed {
        t_pix                   pix;
        logic [LB_ADDR_W-1:0]   addr;
        logic [BANK_W-1:0]      wbank;
        logic                   emit;
        logic                   last;
        logic [WIN_N-1:0]       row_vld;
        logic [WIN_N-1:0]       col_vld;
    } t_ctl;

endpackage

[src/gb5_linebuf.sv]
// ----------------------------------------------------------------------------
// gb5_linebuf - four row buffers
// one bank per row, all read at the same column each beat, read data
// registered and rotated so that the oldest row comes first
// ----------------------------------------------------------------------------
module gb5_linebuf import gb5_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [LB_ADDR_W-1:0] i_addr,
    input  logic [BANK_W-1:0]    i_wbank,
    input  t_pix                 i_wdata,
    output t_lcol                o_col
);

    logic [PIX_W-1:0]  r_mem [NUM_BANKS][MAX_WIDTH];
    t_lcol             r_rd;
    logic [BANK_W-1:0] r_rot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                if (i_wbank == BANK_W'(b)) begin
                    r_mem[b][i_addr] <= i_wdata;
                end
                r_rd[b] <= r_mem[b][i_addr];
            end
            r_rot <= i_wbank;
        end
    end

    always_comb begin
        for (int y = 0; y < NUM_BANKS; y++) begin
            o_col[y] = r_rd[BANK_W'(r_rot + BANK_W'(y))];
        end
    end

endmodule

[src/gb5_ctrl.sv]
// ----------------------------------------------------------------------------
// gb5_ctrl - frame position counters
// tracks input and output raster positions, decides which beats give a
// result and which window taps fall inside the frame
// ----------------------------------------------------------------------------
module gb5_ctrl import gb5_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_action,
    input  t_pix             i_pix,
    input  logic [DIM_W-1:0] i_img_w,
    input  logic [DIM_W-1:0] i_img_h,
    output t_ctl             o_ctl
);

    logic [DIM_W-1:0]  w, h;
    logic              restart, emit, last;
    logic [COL_W-1:0]  r_in_col, in_col, n_in_col;
    logic [DIM_W-1:0]  r_in_row, in_row, n_in_row;
    logic [COL_W-1:0]  r_out_col, out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, out_row, n_out_row;

    always_comb begin
        w = (i_img_w < MIN_DIM_V) ? MIN_DIM_V :
            ((i_img_w > WIDTH_CAP_V) ? WIDTH_CAP_V : i_img_w);
        h = (i_img_h < MIN_DIM_V) ? MIN_DIM_V :
            ((i_img_h > HEIGHT_CAP_V) ? HEIGHT_CAP_V : i_img_h);

        restart = (DIM_W'(r_in_col) >= w) ||
                  ((DIM_W + 1)'(r_in_row) >= ((DIM_W + 1)'(h) + (DIM_W + 1)'(3))) ||
                  (DIM_W'(r_out_col) >= w) || (DIM_W'(r_out_row) >= h);

        in_col  = restart ? '0 : r_in_col;
        in_row  = restart ? '0 : r_in_row;
        out_col = restart ? '0 : r_out_col;
        out_row = restart ? '0 : r_out_row;

        emit = (in_row > DIM_W'(2)) || ((in_row == DIM_W'(2)) && (in_col >= COL_W'(2)));
        last = (DIM_W'(out_row) == (h - DIM_W'(1))) && (DIM_W'(out_col) == (w - DIM_W'(1)));

        n_in_col  = in_col;
        n_in_row  = in_row;
        n_out_col = out_col;
        n_out_row = out_row;
        if (emit && last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else begin
            if (emit) begin
                if ((DIM_W'(out_col) + DIM_W'(1)) == w) begin
                    n_out_col = '0;
                    n_out_row = out_row + OROW_W'(1);
                end else begin
                    n_out_col = out_col + COL_W'(1);
                end
            end
            if ((DIM_W'(in_col) + DIM_W'(1)) == w) begin
                n_in_col = '0;
                n_in_row = in_row + DIM_W'(1);
            end else begin
                n_in_col = in_col + COL_W'(1);
            end
        end

        o_ctl.pix   = (!i_action && (in_row < h)) ? i_pix : '0;
        o_ctl.addr  = LB_ADDR_W'(in_col);
        o_ctl.wbank = in_row[BANK_W-1:0];
        o_ctl.emit  = emit;
        o_ctl.last  = last;

        o_ctl.row_vld[0] = out_row >= OROW_W'(2);
        o_ctl.row_vld[1] = out_row >= OROW_W'(1);
        o_ctl.row_vld[2] = 1'b1;
        o_ctl.row_vld[3] = (DIM_W'(out_row) + DIM_W'(1)) < h;
        o_ctl.row_vld[4] = (DIM_W'(out_row) + DIM_W'(2)) < h;

        o_ctl.col_vld[0] = out_col >= COL_W'(2);
        o_ctl.col_vld[1] = out_col >= COL_W'(1);
        o_ctl.col_vld[2] = 1'b1;
        o_ctl.col_vld[3] = (DIM_W'(out_col) + DIM_W'(1)) < w;
        o_ctl.col_vld[4] = (DIM_W'(out_col) + DIM_W'(2)) < w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

[src/gb5_cell.sv]
// ----------------------------------------------------------------------------
// gb5_cell - one window column
// holds five pixels of one kernel column, shifts from its right neighbor
// and folds the masked taps into symmetric per-channel pair sums
// ----------------------------------------------------------------------------
module gb5_cell import gb5_pkg::*; (
    input  logic             i_clk,
    input  logic             i_shift,
    input  t_wcol            i_col,
    input  logic             i_col_vld,
    input  logic [WIN_N-1:0] i_row_vld,
    output t_wcol            o_col,
    output t_psum            o_psum
);

    t_wcol r_col;
    t_wcol masked;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        for (int y = 0; y < WIN_N; y++) begin
            masked[y] = (i_col_vld && i_row_vld[y]) ? r_col[y] : '0;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            o_psum.outer[c] = PAIR_W'(masked[0][c*CH_W +: CH_W])
                            + PAIR_W'(masked[4][c*CH_W +: CH_W]);
            o_psum.mid[c]   = PAIR_W'(masked[1][c*CH_W +: CH_W])
                            + PAIR_W'(masked[3][c*CH_W +: CH_W]);
            o_psum.ctr[c]   = masked[2][c*CH_W +: CH_W];
        end
    end

    assign o_col = r_col;

endmodule

[src/gaussian_blur_5x5_rgb_top.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb_top - 5x5 gaussian blur of an rgb pixel stream
// Input beats carry raster-order pixels on s_axis (tdata red/green/blue,
// tuser set for a drain beat with no pixel). Output beats on m_axis carry
// the blurred pixel, tlast set on the last pixel of the frame.
// A frame takes width*height pixel beats then 2*width+2 drain beats; the
// result for a pixel leaves with the beat 2*width+2 positions later.
// Five register stages (line buffer read, window shift, class sums,
// multiplies, accumulate and saturate), the last being the output register.
// Throughput is one beat per cycle while the receiver does not stall, set
// by the single read and write per cycle on each row buffer bank and the
// one-column shift of the window. Reset clears the position counters and
// pipeline valids; geometry and weights return to 640x480 and the sigma 1.5
// kernel. Row buffers are not cleared: taps outside the frame are masked.
// When the receiver stalls, the pipeline fills bubbles first and then
// drops s_axis_tready; nothing is lost. Configuration is written via
// i_cfg_we/i_cfg_addr/i_cfg_wdata by the user only while idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`include "gaussian_blur_5x5_rgb_top_defines.svh"

module gaussian_blur_5x5_rgb_top import gb5_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  s_axis_tuser,  // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  m_axis_tlast   // frame_last
);

    logic [DIM_W-1:0]  r_img_w, r_img_h;
    logic [COEF_W-1:0] r_coef [NUM_CLS];

    logic   accept, rdy1, rdy2, rdy3, rdy4, rdy5, shift2;
    t_ctl   ctl;
    t_lcol  lb_col;
    t_wcol  w_col [WIN_N+1];
    t_psum  ps [WIN_N];

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    t_pix             r_s1_pix;
    logic             r_s1_emit, r_s1_last;
    logic [WIN_N-1:0] r_s1_rvld, r_s1_cvld;
    logic             r_s2_emit, r_s2_last;
    logic [WIN_N-1:0] r_s2_rvld, r_s2_cvld;
    t_csum            csum [NUM_CH];
    t_csum            r_s3_csum [NUM_CH];
    logic             r_s3_last;
    t_prod            r_s4_prod [NUM_CH];
    logic             r_s4_last;
    logic [ACC_W-1:0] acc [NUM_CH];
    t_pix             sat;
    t_pix             r_out_pix;
    logic             r_out_last;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_IMAGE_WIDTH;
            r_img_h <= RST_IMAGE_HEIGHT;
            for (int k = 0; k < NUM_CLS; k++) begin
                r_coef[k] <= RST_COEF[k];
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_wdata[DIM_W-1:0];
                REG_COEF_D0:      r_coef[CLS_D0] <= i_cfg_wdata;
                REG_COEF_D1:      r_coef[CLS_D1] <= i_cfg_wdata;
                REG_COEF_D2:      r_coef[CLS_D2] <= i_cfg_wdata;
                REG_COEF_D4:      r_coef[CLS_D4] <= i_cfg_wdata;
                REG_COEF_D5:      r_coef[CLS_D5] <= i_cfg_wdata;
                REG_COEF_D8:      r_coef[CLS_D8] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // stall chain
    assign rdy5   = !r_v5 || m_axis_tready;
    assign rdy4   = !r_v4 || rdy5;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign accept = s_axis_tvalid && rdy1;
    assign shift2 = r_v1 && rdy2;
    assign s_axis_tready = rdy1;

    gb5_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (s_axis_tuser),
        .i_pix    (s_axis_tdata),
        .i_img_w  (r_img_w),
        .i_img_h  (r_img_h),
        .o_ctl    (ctl)
    );

    gb5_linebuf u_linebuf (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (ctl.addr),
        .i_wbank (ctl.wbank),
        .i_wdata (ctl.pix),
        .o_col   (lb_col)
    );

    // stage 1: side info next to the row buffer read data
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_pix  <= ctl.pix;
            r_s1_emit <= ctl.emit;
            r_s1_last <= ctl.last;
            r_s1_rvld <= ctl.row_vld;
            r_s1_cvld <= ctl.col_vld;
        end
    end

    // stage 2: window cells, newest column enters at the right
    always_comb begin
        for (int y = 0; y < NUM_BANKS; y++) begin
            w_col[WIN_N][y] = lb_col[y];
        end
        w_col[WIN_N][WIN_N-1] = r_s1_pix;
    end

    for (genvar k = 0; k < WIN_N; k++) begin : g_cell
        gb5_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (shift2),
            .i_col     (w_col[k+1]),
            .i_col_vld (r_s2_cvld[k]),
            .i_row_vld (r_s2_rvld),
            .o_col     (w_col[k]),
            .o_psum    (ps[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
            r_s2_rvld <= r_s1_rvld;
            r_s2_cvld <= r_s1_cvld;
        end
    end

    // stage 3: sums per distance class
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            csum[c][CLS_D0] = CSUM_W'(ps[2].ctr[c]);
            csum[c][CLS_D1] = CSUM_W'(ps[1].ctr[c]) + CSUM_W'(ps[3].ctr[c])
                            + CSUM_W'(ps[2].mid[c]);
            csum[c][CLS_D2] = CSUM_W'(ps[1].mid[c]) + CSUM_W'(ps[3].mid[c]);
            csum[c][CLS_D4] = CSUM_W'(ps[0].ctr[c]) + CSUM_W'(ps[4].ctr[c])
                            + CSUM_W'(ps[2].outer[c]);
            csum[c][CLS_D5] = CSUM_W'(ps[0].mid[c]) + CSUM_W'(ps[4].mid[c])
                            + CSUM_W'(ps[1].outer[c]) + CSUM_W'(ps[3].outer[c]);
            csum[c][CLS_D8] = CSUM_W'(ps[0].outer[c]) + CSUM_W'(ps[4].outer[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_csum <= csum;
            r_s3_last <= r_s2_last;
        end
    end

    // stage 4: weights
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            for (int c = 0; c < NUM_CH; c++) begin
                for (int k = 0; k < NUM_CLS; k++) begin
                    r_s4_prod[c][k] <= PROD_W'(r_s3_csum[c][k]) * PROD_W'(r_coef[k]);
                end
            end
            r_s4_last <= r_s3_last;
        end
    end

    // stage 5: accumulate, truncate, saturate
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc[c] = '0;
            for (int k = 0; k < NUM_CLS; k++) begin
                acc[c] = acc[c] + ACC_W'(r_s4_prod[c][k]);
            end
            sat[c*CH_W +: CH_W] = (acc[c][ACC_W-1:COEF_FRAC+CH_W] != '0) ?
                                  {CH_W{1'b1}} : acc[c][COEF_FRAC+CH_W-1:COEF_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_out_pix  <= sat;
            r_out_last <= r_s4_last;
        end
    end

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2 && r_s2_emit;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    `GB5_ASSERT_NEXT(a_accept_lands, accept, r_v1, "beat lost at stage one")
    `GB5_ASSERT_NEXT(a_window_holds, r_v2 && !rdy3, r_v2, "window beat dropped while stalled")
    `GB5_ASSERT_NEXT(a_prod_to_out, r_v4 && rdy5, r_v5, "product beat did not reach output")
    `GB5_ASSERT_NOW(a_full_stall, !rdy4 && r_v1 && r_v2 && r_v3, !s_axis_tready, "full but ready")

endmodule

[tb/gaussian_blur_5x5_rgb_top_tb.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb_top_tb - stream-level testbench for the 5x5 rgb blur
// Feeds raster-order frames through s_axis, keeps a cycle-free model of the
// line buffers, shift window and position counters, and checks every m_axis
// beat against the oldest predicted pixel. Geometry and kernel weights are
// reprogrammed between phases while the pipeline is empty. Covers a directed
// frame, one long wide partial frame and many small noisy frames with random
// stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gaussian_blur_5x5_rgb_top_tb;
    import gb5_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_ITEMS  = 1150;
    localparam int WIDE_W      = 256;

    localparam int TAP_CLS [WIN_N][WIN_N] = '{
        '{CLS_D8, CLS_D5, CLS_D4, CLS_D5, CLS_D8},
        '{CLS_D5, CLS_D2, CLS_D1, CLS_D2, CLS_D5},
        '{CLS_D4, CLS_D1, CLS_D0, CLS_D1, CLS_D4},
        '{CLS_D5, CLS_D2, CLS_D1, CLS_D2, CLS_D5},
        '{CLS_D8, CLS_D5, CLS_D4, CLS_D5, CLS_D8}
    };

    localparam logic [PIX_W-1:0] PATTERNS [6] = '{
        24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55, 24'hFF00FF, 24'h0F80F1
    };

    typedef struct packed {
        logic                          drain;
        logic [NUM_CH-1:0][CH_W-1:0]   rgb;
    } t_pix_beat;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0]   rgb;
        logic                          last;
    } t_blur_px;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;  // red_in, green_in, blue_in
    logic                  s_axis_tuser = 1'b0;  // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;  // red_out, green_out, blue_out
    logic                  m_axis_tlast;  // frame_last

    gaussian_blur_5x5_rgb_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // stimulus and expected pixels
    t_pix_beat   pending_q [$];
    t_blur_px    blurred_q [$];
    bit          steady = 1'b0;
    logic        in_fire = 1'b0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          rand_items = 0;

    // blur model state
    logic [CFG_DATA_W-1:0] cfg_reg [8];
    logic [PIX_W-1:0]      line_mem [NUM_BANKS * MAX_WIDTH];
    logic [PIX_W-1:0]      win [WIN_N][WIN_N];
    int unsigned           in_col = 0;
    int unsigned           in_row = 0;
    int unsigned           out_col = 0;
    int unsigned           out_row = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] raw,
                                            input int unsigned cap);
        int unsigned v;
        v = 32'(raw);
        if (v < 5)
            v = 5;
        if (v > cap)
            v = cap;
        return v;
    endfunction

    function automatic void clear_pos();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    task automatic blur_step(input t_pix_beat b, output bit made, output t_blur_px res);
        int unsigned w;
        int unsigned h;
        logic [PIX_W-1:0] pix;
        longint acc;
        int rr;
        int cc;
        w = eff_dim(cfg_reg[REG_IMAGE_WIDTH], WIDTH_CAP);
        h = eff_dim(cfg_reg[REG_IMAGE_HEIGHT], MAX_DIM);
        made = 1'b0;
        res = '0;
        if (in_col >= w || in_row >= h + 3 || out_col >= w || out_row >= h)
            clear_pos();
        pix = (!b.drain && in_row < h) ? b.rgb : '0;
        for (int y = 0; y < WIN_N; y++)
            for (int k = 0; k < WIN_N - 1; k++)
                win[y][k] = win[y][k + 1];
        for (int y = 0; y < WIN_N - 1; y++)
            win[y][WIN_N - 1] = line_mem[((in_row + y) % NUM_BANKS) * MAX_WIDTH + in_col];
        win[WIN_N - 1][WIN_N - 1] = pix;
        line_mem[(in_row % NUM_BANKS) * MAX_WIDTH + in_col] = pix;
        if (in_row > 2 || (in_row == 2 && in_col >= 2)) begin
            made = 1'b1;
            res.last = (out_row == h - 1 && out_col == w - 1);
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc = 0;
                for (int y = 0; y < WIN_N; y++)
                    for (int k = 0; k < WIN_N; k++) begin
                        rr = int'(out_row) - 2 + y;
                        cc = int'(out_col) - 2 + k;
                        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                            acc += longint'(win[y][k][CH_W*ch +: CH_W]) *
                                   longint'(cfg_reg[REG_COEF_D0 + TAP_CLS[y][k]]);
                    end
                acc = acc >> COEF_FRAC;
                res.rgb[ch] = (acc > 255) ? 8'hFF : acc[7:0];
            end
            if (res.last) begin
                clear_pos();
                return;
            end
            out_col++;
            if (out_col == w) begin
                out_col = 0;
                out_row++;
            end
        end
        in_col++;
        if (in_col == w) begin
            in_col = 0;
            in_row++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        t_pix_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (pending_q.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
                nxt = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.rgb;
                s_axis_tuser  <= nxt.drain;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && (steady || $urandom_range(99) >= 20);
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_blur_px want;
        t_blur_px pred;
        bit made;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (blurred_q.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, got %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end else begin
                    want = blurred_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++)
                        if (m_axis_tdata[CH_W*ch +: CH_W] !== want.rgb[ch]) begin
                            $display("%0t: channel %0d expected %0d got %0d", $time, ch,
                                     want.rgb[ch], m_axis_tdata[CH_W*ch +: CH_W]);
                            err_cnt++;
                        end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: frame last expected %b got %b", $time,
                                 want.last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                blur_step(t_pix_beat'({s_axis_tuser, s_axis_tdata}), made, pred);
                if (made)
                    blurred_q.push_back(pred);
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        cfg_reg[idx] = (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) ?
                       (val & 16'h0FFF) : val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_setup(input logic [CFG_DATA_W-1:0] w_raw,
                              input logic [CFG_DATA_W-1:0] h_raw, input int mode);
        logic [CFG_DATA_W-1:0] c;
        write_reg(REG_IMAGE_WIDTH, w_raw);
        write_reg(REG_IMAGE_HEIGHT, h_raw);
        for (int k = 0; k < NUM_CLS; k++) begin
            case (mode)
                0: c = RST_COEF[k];
                1: c = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                2: c = CFG_DATA_W'($urandom_range(65535));
                default: c = CFG_DATA_W'($urandom_range(5000));
            endcase
            write_reg(CFG_ADDR_W'(REG_COEF_D0 + k), c);
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_axis_tvalid || blurred_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [NUM_CH-1:0][CH_W-1:0] rand_rgb();
        logic [NUM_CH-1:0][CH_W-1:0] v;
        for (int ch = 0; ch < NUM_CH; ch++)
            case ($urandom_range(7))
                0: v[ch] = 8'h00;
                1: v[ch] = 8'hFF;
                default: v[ch] = CH_W'($urandom_range(255));
            endcase
        return v;
    endfunction

    task automatic send_frame(input int w, input int h, input int cut, input int pause_at);
        int n;
        bit drain;
        n = w * h + 2 * w + 2;
        for (int pos = 0; pos < n; pos++) begin
            if (pos == cut)
                break;
            if (pos == pause_at)
                wait_drained();
            if (pos < w * h)
                drain = ($urandom_range(19) == 0);
            else
                drain = ($urandom_range(4) != 0);
            pending_q.push_back('{drain: drain, rgb: rand_rgb()});
            rand_items++;
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;
        int w;
        int h;
        int n;
        int frames;
        int cut;
        int phase;
        cfg_reg[REG_IMAGE_WIDTH]  = CFG_DATA_W'(RST_IMAGE_WIDTH);
        cfg_reg[REG_IMAGE_HEIGHT] = CFG_DATA_W'(RST_IMAGE_HEIGHT);
        for (int k = 0; k < NUM_CLS; k++)
            cfg_reg[REG_COEF_D0 + k] = RST_COEF[k];
        for (int i = 0; i < NUM_BANKS * MAX_WIDTH; i++)
            line_mem[i] = '0;
        for (int y = 0; y < WIN_N; y++)
            for (int k = 0; k < WIN_N; k++)
                win[y][k] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(posedge i_clk);

        // directed 5x5 frame: extreme samples, drain inside the frame,
        // pixel among the drain beats
        write_reg(REG_IMAGE_WIDTH, 16'd5);
        write_reg(REG_IMAGE_HEIGHT, 16'd5);
        write_reg(REG_COEF_D0, 16'hFFFF);
        write_reg(REG_COEF_D1, 16'h0000);
        write_reg(REG_COEF_D2, 16'h1000);
        write_reg(REG_COEF_D4, 16'h0001);
        write_reg(REG_COEF_D5, 16'h0800);
        write_reg(REG_COEF_D8, 16'hFFFF);
        for (int i = 0; i < 25; i++) begin
            pending_q.push_back('{drain: (i == 12), rgb: PATTERNS[i % 6]});
            rand_items++;
        end
        for (int i = 0; i < 12; i++) begin
            pending_q.push_back('{drain: (i != 5), rgb: 24'hFFFFFF});
            rand_items++;
        end
        settle();

        // wide rows at the tallest geometry, partial frame without idling
        steady = 1'b1;
        load_setup(CFG_DATA_W'(WIDE_W), 16'hFFFF, 3);
        for (int i = 0; i < 2 * WIDE_W + 32; i++) begin
            pending_q.push_back('{drain: 1'b0, rgb: rand_rgb()});
            rand_items++;
        end
        settle();
        steady = 1'b0;

        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            settle();
            w_raw = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(4) :
                                                           $urandom_range(5, 9));
            h_raw = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(4) :
                                                           $urandom_range(5, 8));
            w = eff_dim(w_raw, WIDTH_CAP);
            h = eff_dim(h_raw, MAX_DIM);
            n = w * h + 2 * w + 2;
            load_setup(w_raw, h_raw, $urandom_range(3));
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                cut = (f == frames - 1 && $urandom_range(5) == 0) ?
                      int'($urandom_range(n - 1)) : -1;
                send_frame(w, h, cut, (phase == 3 && f == 0) ? (w * h) / 2 : -1);
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
